[hdl/keyed_record_table_oldest_evict_defines.svh]
// Assertion macros shared by the checker.
`ifndef KEYED_RECORD_TABLE_OLDEST_EVICT_DEFINES_SVH
`define KEYED_RECORD_TABLE_OLDEST_EVICT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define KRT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbl failed");
// Next-cycle implication checked outside reset.
`define KRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbl failed");
`endif

[hdl/krt_pkg.sv]
// ---------------------------------------------------------------------------
// krt_pkg
// Shared types and codes of the keyed record table.
// ---------------------------------------------------------------------------
package krt_pkg;
  localparam int unsigned FuncWidth = 3;
  localparam int unsigned InWidth   = 136;
  localparam int unsigned OutWidth  = 136;

  typedef enum logic [2:0] {
    FUNC_UPSERT = 3'd0,
    FUNC_FIND   = 3'd1,
    FUNC_REMOVE = 3'd2,
    FUNC_LATEST = 3'd3,
    FUNC_LISTF  = 3'd4,
    FUNC_LISTN  = 3'd5,
    FUNC_CLEAR  = 3'd6,
    FUNC_NONE   = 3'd7
  } func_e;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_KEY = 2'd1;
  localparam logic [1:0] STAT_NONE     = 2'd2;

  typedef struct packed {
    logic [31:0] uid;
    logic [7:0]  evt_code;
    logic [7:0]  evt_mask;
    logic [7:0]  cat_code;
    logic [7:0]  cat_total;
    logic [63:0] timestamp;
    logic        detail_done;
  } rec_t;
endpackage

[hdl/krt_ctrl.sv]
// ---------------------------------------------------------------------------
// krt_ctrl
// Sequencer: steps the slot scan, the list selection and the result transfer.
// ---------------------------------------------------------------------------
module krt_ctrl import krt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  input  logic scan_last_i,
  input  logic list_done_i,
  input  logic is_list_i,
  output logic start_o,
  output logic scan_o,
  output logic finish_o,
  output logic pick_o,
  output logic take_o,
  output logic emit_o
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIN, S_PICK, S_TAKE, S_OUT} state_e;
  state_e state_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign start_o     = in_valid_i && in_ready_o;
  assign scan_o      = (state_q == S_SCAN);
  assign finish_o    = (state_q == S_FIN);
  assign pick_o      = (state_q == S_PICK);
  assign take_o      = (state_q == S_TAKE);
  assign emit_o      = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (start_o) state_q <= S_SCAN;
        S_SCAN: if (scan_last_i) state_q <= S_FIN;
        S_FIN:  state_q <= is_list_i ? S_PICK : S_OUT;
        S_PICK: if (scan_last_i) state_q <= S_TAKE;
        S_TAKE: state_q <= S_OUT;
        S_OUT: begin
          if (out_ready_i) begin
            if (is_list_i && !list_done_i) state_q <= S_PICK;
            else state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/krt_datapath.sv]
// ---------------------------------------------------------------------------
// krt_datapath
// Slot registers, scan comparators, selection mask and result register.
// ---------------------------------------------------------------------------
module krt_datapath import krt_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [FuncWidth-1:0] in_func_i,
  input  logic [InWidth-1:0]   in_data_i,
  input  logic                 start_i,
  input  logic                 scan_i,
  input  logic                 finish_i,
  input  logic                 pick_i,
  input  logic                 take_i,
  input  logic                 emit_i,
  output logic                 scan_last_o,
  output logic                 list_done_o,
  output logic                 is_list_o,
  output logic [OutWidth-1:0]  out_data_o,
  output logic                 out_last_o
);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Depth-1:0] valid_q;
  rec_t             slot_q [Depth];
  logic [CntW-1:0]  count_q;

  func_e       func_q;
  rec_t        in_rec_q;
  logic [4:0]  limit_q;
  logic [IdxW-1:0] idx_q;
  logic        hit_q, free_q, best_ok_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q, best_q;
  logic [63:0] best_t_q;
  logic [Depth-1:0] sel_q;
  logic [4:0]  taken_q, remain_q;
  rec_t        out_rec_q;
  logic [1:0]  out_stat_q;
  logic        out_last_q;
  logic        pk_ok_q;
  logic [63:0] pk_t_q;
  logic [IdxW-1:0] pk_idx_q;

  rec_t cur;
  logic cur_v;
  logic [4:0] lim_sat;
  assign cur   = slot_q[idx_q];
  assign cur_v = valid_q[idx_q];
  assign lim_sat = (limit_q > 5'd16) ? 5'd16 : limit_q;
  assign is_list_o   = (func_q == FUNC_LISTF) || (func_q == FUNC_LISTN);
  assign scan_last_o = (idx_q == IdxW'(Depth - 1));

  // One pass per list result finds the newest selected slot, lowest index on ties.
  always_ff @(posedge clk_i) begin
    if (finish_i || take_i) begin
      pk_ok_q <= 1'b0;
    end else if (pick_i && sel_q[idx_q] && (!pk_ok_q || cur.timestamp > pk_t_q)) begin
      pk_ok_q  <= 1'b1;
      pk_t_q   <= cur.timestamp;
      pk_idx_q <= idx_q;
    end
  end
  assign list_done_o = (remain_q == 5'd0) || (sel_q == '0);

  logic [4:0] cnt_sat;
  assign cnt_sat = (32'(count_q) > 32'd31) ? 5'd31 : 5'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      func_q  <= FUNC_NONE;
    end else begin
      if (start_i) begin
        func_q <= func_e'(in_func_i);
      end
      if (start_i || finish_i || take_i) begin
        idx_q <= '0;
      end else if (scan_i || pick_i) begin
        idx_q <= idx_q + 1'b1;
      end
      if (finish_i) begin
        case (func_q)
          FUNC_UPSERT: begin
            if (in_rec_q.uid != 32'd0) begin
              if (hit_q) begin
                valid_q[hit_idx_q] <= 1'b1;
              end else if (free_q) begin
                valid_q[free_idx_q] <= 1'b1;
                count_q <= count_q + 1'b1;
              end
            end
          end
          FUNC_REMOVE: begin
            if (hit_q) begin
              valid_q[hit_idx_q] <= 1'b0;
              if (count_q != '0) count_q <= count_q - 1'b1;
            end
          end
          FUNC_CLEAR: begin
            valid_q <= '0;
            count_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  logic [IdxW-1:0] up_idx;
  assign up_idx = hit_q ? hit_idx_q : (free_q ? free_idx_q : best_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_rec_q.uid         <= in_data_i[31:0];
      in_rec_q.evt_code    <= in_data_i[39:32];
      in_rec_q.evt_mask    <= in_data_i[47:40];
      in_rec_q.cat_code    <= in_data_i[55:48];
      in_rec_q.cat_total   <= in_data_i[63:56];
      in_rec_q.timestamp   <= in_data_i[127:64];
      in_rec_q.detail_done <= in_data_i[128];
      limit_q   <= in_data_i[133:129];
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      best_ok_q <= 1'b0;
      sel_q     <= '0;
      taken_q   <= '0;
    end else if (scan_i) begin
      if (cur_v && cur.uid == in_rec_q.uid && !hit_q) begin
        hit_q <= 1'b1;
        hit_idx_q <= idx_q;
      end
      if (!cur_v && !free_q) begin
        free_q <= 1'b1;
        free_idx_q <= idx_q;
      end
      if (func_q == FUNC_LATEST) begin
        if (cur_v && (!best_ok_q || cur.timestamp >= best_t_q)) begin
          best_ok_q <= 1'b1; best_t_q <= cur.timestamp; best_q <= idx_q;
        end
      end else if (cur_v && (!best_ok_q || cur.timestamp <= best_t_q)) begin
        best_ok_q <= 1'b1; best_t_q <= cur.timestamp; best_q <= idx_q;
      end
      if (cur_v && (func_q == FUNC_LISTN || taken_q < lim_sat)) begin
        sel_q[idx_q] <= 1'b1;
        taken_q <= taken_q + 1'b1;
      end
    end
    if (finish_i) begin
      remain_q   <= lim_sat;
      out_rec_q  <= '0;
      out_last_q <= 1'b1;
      case (func_q)
        FUNC_UPSERT: begin
          if (in_rec_q.uid == 32'd0) begin
            out_stat_q <= STAT_ZERO_KEY;
          end else begin
            slot_q[up_idx] <= in_rec_q;
            out_rec_q  <= in_rec_q;
            out_stat_q <= STAT_OK;
          end
        end
        FUNC_FIND, FUNC_REMOVE: begin
          out_stat_q <= hit_q ? STAT_OK : STAT_NONE;
          if (hit_q) out_rec_q <= slot_q[hit_idx_q];
        end
        FUNC_LATEST: begin
          out_stat_q <= best_ok_q ? STAT_OK : STAT_NONE;
          if (best_ok_q) out_rec_q <= slot_q[best_q];
        end
        FUNC_CLEAR: out_stat_q <= STAT_OK;
        default:    out_stat_q <= STAT_NONE;
      endcase
    end
    if (take_i) begin
      if (lim_sat == 5'd0 || !pk_ok_q) begin
        out_rec_q  <= '0;
        out_stat_q <= STAT_NONE;
        out_last_q <= 1'b1;
        remain_q   <= '0;
        sel_q      <= '0;
      end else begin
        out_rec_q  <= slot_q[pk_idx_q];
        out_stat_q <= STAT_OK;
        sel_q[pk_idx_q] <= 1'b0;
        remain_q   <= remain_q - 1'b1;
        out_last_q <= (remain_q == 5'd1) || ((sel_q & ~(Depth'(1) << pk_idx_q)) == '0);
      end
    end
    if (emit_i && out_last_q) remain_q <= '0;
  end

  assign out_last_o = out_last_q;
  assign out_data_o = {cnt_sat, out_stat_q,
                       out_rec_q.detail_done, out_rec_q.timestamp,
                       out_rec_q.cat_total, out_rec_q.cat_code,
                       out_rec_q.evt_mask, out_rec_q.evt_code, out_rec_q.uid};
endmodule

[hdl/keyed_record_table_oldest_evict.sv]
// ---------------------------------------------------------------------------
// keyed_record_table_oldest_evict
// Keyed record table with oldest-timestamp replacement, stream interface.
// ---------------------------------------------------------------------------
// A single result follows the slot scan and a finish step; a list operation then runs
// a selection pass and a take step before its first result.
// Each further list result takes its own selection pass and take step.
// A new operation is accepted only when idle, after the last result has been taken.
// The slot scan and the selection pass each examine one slot register per cycle.
// Reset clears all valid bits and the entry count; slot data is not reset.
module keyed_record_table_oldest_evict import krt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // func
  input  logic [FuncWidth-1:0] s_axis_tuser,
  // uid, evt_code, evt_mask, cat_code, cat_total, timestamp, detail_done,
  // list_limit, zero padding
  input  logic [InWidth-1:0]   s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // rec_uid, rec_evt_code, rec_evt_mask, rec_cat_code, rec_cat_total,
  // rec_timestamp, rec_detail_done, status, entry_count
  output logic [OutWidth-1:0]  m_axis_tdata,
  output logic                 m_axis_tlast
);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic scan_last, list_done, is_list, start, scan, finish, pick, take, emit;

  krt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .scan_last_i(scan_last), .list_done_i(list_done), .is_list_i(is_list),
    .start_o(start), .scan_o(scan), .finish_o(finish), .pick_o(pick),
    .take_o(take), .emit_o(emit)
  );

  krt_datapath #(.Depth(TABLE_DEPTH), .IdxW(IdxW)) u_dp (
    .clk_i, .rst_ni,
    .in_func_i(s_axis_tuser),
    .in_data_i(s_axis_tdata),
    .start_i(start), .scan_i(scan), .finish_i(finish), .pick_i(pick),
    .take_i(take), .emit_i(emit),
    .scan_last_o(scan_last), .list_done_o(list_done), .is_list_o(is_list),
    .out_data_o(m_axis_tdata), .out_last_o(m_axis_tlast)
  );
endmodule

[hdl/krt_checker.sv]
// ---------------------------------------------------------------------------
// krt_checker
// Port-level checks of the keyed record table.
// ---------------------------------------------------------------------------
`include "keyed_record_table_oldest_evict_defines.svh"
module krt_checker import krt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutWidth-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);
  `KRT_ASSERT_IMPL(a_no_overlap, m_axis_tvalid, !s_axis_tready)
  `KRT_ASSERT_IMPL(a_count_range, m_axis_tvalid, m_axis_tdata[135:131] <= 5'd16)
  `KRT_ASSERT_IMPL(a_status_range, m_axis_tvalid, m_axis_tdata[130:129] != 2'd3)
  `KRT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
endmodule

bind keyed_record_table_oldest_evict krt_checker u_krt_checker (.*);
